// ===== hdl/lpd_pkg.sv =====
package lpd_pkg;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_HEADER_SIZE_FOUR  = 1'b0,
      CSR_BYTE_ORDER_LITTLE = 1'b1
   } csr_index_type;

   // Index of the final header byte for each header size
   localparam logic [1:0] HDR_LAST_TWO  = 2'd1;
   localparam logic [1:0] HDR_LAST_FOUR = 2'd3;

   localparam int unsigned RSP_DATA_W = 40;

   typedef struct packed {
      logic header_size_four;
      logic byte_order_little;
   } cfg_type;

   typedef struct packed {
      logic [31:0] message_length;
      logic        end_of_message;
      logic        has_byte;
      logic [7:0]  payload_byte;
   } result_type;

endpackage

// ===== hdl/lpd_parser.sv =====
module lpd_parser
   import lpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       word_accept,
   input  logic [7:0] stream_byte,
   output logic       result_valid,
   output result_type result
);

   logic [31:0] header_accum_ff,    header_accum_in;
   logic [1:0]  header_seen_ff,     header_seen_in;
   logic        in_payload_ff,      in_payload_in;
   logic [31:0] bytes_remaining_ff, bytes_remaining_in;
   logic [31:0] current_length_ff,  current_length_in;

   logic [31:0] accum_next;
   logic [31:0] decoded_length;
   logic [1:0]  last_index;
   logic        payload_last;

   // Merge the incoming header byte into the accumulator
   always_comb begin
      accum_next = {header_accum_ff[23:0], stream_byte};
      if (cfg.byte_order_little) begin
         accum_next = header_accum_ff;
         for (int lane = 0; lane < 4; lane++) begin
            if (header_seen_ff == 2'(lane)) begin
               accum_next[lane*8 +: 8] = stream_byte;
            end
         end
      end
   end

   assign last_index     = cfg.header_size_four ? HDR_LAST_FOUR : HDR_LAST_TWO;
   assign decoded_length = cfg.header_size_four ? accum_next : {16'h0000, accum_next[15:0]};
   assign payload_last   = (bytes_remaining_ff <= 32'd1);

   // Next state and result for one accepted word
   always_comb begin
      header_accum_in    = header_accum_ff;
      header_seen_in     = header_seen_ff;
      in_payload_in      = in_payload_ff;
      bytes_remaining_in = bytes_remaining_ff;
      current_length_in  = current_length_ff;
      result_valid       = 1'b0;
      result             = '0;
      if (word_accept) begin
         if (in_payload_ff) begin
            result_valid          = 1'b1;
            result.payload_byte   = stream_byte;
            result.has_byte       = 1'b1;
            result.end_of_message = payload_last;
            result.message_length = current_length_ff;
            if (payload_last) begin
               bytes_remaining_in = '0;
               in_payload_in      = 1'b0;
            end else begin
               bytes_remaining_in = bytes_remaining_ff - 32'd1;
            end
         end else if (header_seen_ff < last_index) begin
            header_accum_in = accum_next;
            header_seen_in  = header_seen_ff + 2'd1;
         end else begin
            header_accum_in = '0;
            header_seen_in  = '0;
            if (decoded_length == 32'd0) begin
               // empty message: emit a marker and expect the next header
               current_length_in     = '0;
               bytes_remaining_in    = '0;
               result_valid          = 1'b1;
               result.end_of_message = 1'b1;
            end else begin
               current_length_in  = decoded_length;
               bytes_remaining_in = decoded_length;
               in_payload_in      = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_accum_ff    <= '0;
         header_seen_ff     <= '0;
         in_payload_ff      <= 1'b0;
         bytes_remaining_ff <= '0;
         current_length_ff  <= '0;
      end else begin
         header_accum_ff    <= header_accum_in;
         header_seen_ff     <= header_seen_in;
         in_payload_ff      <= in_payload_in;
         bytes_remaining_ff <= bytes_remaining_in;
         current_length_ff  <= current_length_in;
      end
   end

endmodule

// ===== hdl/lpd_out_buf.sv =====
module lpd_out_buf
   import lpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  result_type push_data,
   output logic       push_ready,
   output logic       out_valid,
   output result_type out_data,
   input  logic       out_ready
);

   logic       main_valid_ff, main_valid_in;
   result_type main_data_ff,  main_data_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_data_ff,  skid_data_in;

   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_data   = main_data_ff;

   // Hold a result in the skid stage while the output word is stalled
   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_ready) begin
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push_valid) begin
         if (!main_valid_ff || out_ready) begin
            main_valid_in = 1'b1;
            main_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (out_ready) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== hdl/length_prefix_deframer_core.sv =====
// Splits a byte stream into messages, each led by a 2- or 4-byte length header
// (big- or little-endian, set through the csr port; the user must set it only
// while the block is idle, which the block does not enforce). Header words give
// no output; each payload word comes out with its message length in tdata and
// tlast on the final byte; a zero-length header gives one word with tuser low
// and tlast high. One word is taken every cycle while req_tready is high; a
// two-entry output buffer registers each result and drops req_tready while its skid entry is full.
module length_prefix_deframer_core
   import lpd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] stream_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] payload_byte, [39:8] message_length
   output logic                  rsp_tuser,   // [0] has_byte
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic                  csr_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       word_accept;
   logic       result_valid;
   result_type result;
   result_type out_data;

   assign csr_ready   = 1'b1;
   assign word_accept = req_tvalid && req_tready;

   // Write configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_HEADER_SIZE_FOUR:  cfg_in.header_size_four  = csr_data;
            CSR_BYTE_ORDER_LITTLE: cfg_in.byte_order_little = csr_data;
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lpd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .word_accept  (word_accept),
      .stream_byte  (req_tdata),
      .result_valid (result_valid),
      .result       (result)
   );

   lpd_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (result_valid),
      .push_data  (result),
      .push_ready (req_tready),
      .out_valid  (rsp_tvalid),
      .out_data   (out_data),
      .out_ready  (rsp_tready)
   );

   // Pack the result word
   assign rsp_tdata = {out_data.message_length, out_data.payload_byte};
   assign rsp_tuser = out_data.has_byte;
   assign rsp_tlast = out_data.end_of_message;

endmodule
